[src/column_white_run_energy_profile_assert.svh]
`ifndef COLUMN_WHITE_RUN_ENERGY_PROFILE_ASSERT_SVH
`define COLUMN_WHITE_RUN_ENERGY_PROFILE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CREP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crep assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define CREP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crep assertion failed");

`endif

[src/crep_pkg.sv]
package crep_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int COLP_W = COL_W + 1;
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int RUN_W  = ROW_W + 1;
    localparam int SUM_W  = 2 * RUN_W - 1;

    localparam int DIM_W     = 11;
    localparam int COLUMN_W  = 10;
    localparam int FRAC_W    = 16;
    localparam int Q_W       = FRAC_W + 1;
    localparam int CFG_IDX_W = 1;

    localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << FRAC_W;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1024);

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        logic [SUM_W-1:0] data;
    } colmem_wr_t;

    typedef struct packed {
        logic [Q_W-1:0] value;
        logic           max_zero;
    } div_res_t;

endpackage

[src/crep_if.sv]
interface crep_req_if
    import crep_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                cmd;
    logic                pixel;
    logic [COLUMN_W-1:0] column;

    modport source (output valid, output cmd, output pixel, output column, input ready);
    modport sink   (input valid, input cmd, input pixel, input column, output ready);
endinterface

interface crep_rsp_if
    import crep_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [Q_W-1:0]      value_q16;
    logic                max_was_zero;
    logic [COLUMN_W-1:0] column_echo;

    modport source (output valid, output value_q16, output max_was_zero,
                    output column_echo, input ready);
    modport sink   (input valid, input value_q16, input max_was_zero,
                    input column_echo, output ready);
endinterface

[src/crep_colmem.sv]
module crep_colmem
    import crep_pkg::*;
(
    input  logic             clk,
    input  colmem_wr_t       wr,
    input  logic             rd_en,
    input  logic [COL_W-1:0] rd_addr,
    output logic [SUM_W-1:0] rd_data
);

    logic [SUM_W-1:0] mem [MAX_WIDTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/crep_accum.sv]
module crep_accum
    import crep_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pix_en,
    input  logic             pixel,
    input  logic [DIM_W-1:0] image_width,
    input  logic [DIM_W-1:0] image_height,
    output colmem_wr_t       wr,
    output logic [SUM_W-1:0] max_sum
);

    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [RUN_W-1:0] run_reg, run_next;
    logic             prev_reg, prev_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SUM_W-1:0] max_reg, max_next;

    logic [RUN_W-1:0]   h_eff;
    logic [COLP_W-1:0]  w_eff;
    logic               first_row;
    logic               eff_prev;
    logic               extend;
    logic [RUN_W-1:0]   run_inc;
    logic [RUN_W-1:0]   sq_op;
    logic [2*RUN_W-1:0] sq_full;
    logic [RUN_W-1:0]   row_inc;
    logic [COLP_W-1:0]  col_inc;
    logic               col_end;
    logic               wrap;
    logic [SUM_W-1:0]   sum_new;
    logic [SUM_W-1:0]   max_base;
    logic [SUM_W-1:0]   max_new;

    always_comb
    begin
        priority if (image_height == '0)
            h_eff = RUN_W'(1);
        else if (32'(image_height) > MAX_HEIGHT)
            h_eff = RUN_W'(MAX_HEIGHT);
        else
            h_eff = RUN_W'(image_height);

        priority if (image_width == '0)
            w_eff = COLP_W'(1);
        else if (32'(image_width) > MAX_WIDTH)
            w_eff = COLP_W'(MAX_WIDTH);
        else
            w_eff = COLP_W'(image_width);
    end

    assign first_row = (row_reg == '0);
    assign eff_prev  = first_row ? pixel : prev_reg;
    assign extend    = !pixel && !eff_prev;
    assign run_inc   = run_reg + RUN_W'(1);
    assign sq_op     = extend ? run_inc : run_reg;
    assign sq_full   = sq_op * sq_op;
    assign row_inc   = {1'b0, row_reg} + RUN_W'(1);
    assign col_inc   = {1'b0, col_reg} + COLP_W'(1);
    assign col_end   = (row_inc >= h_eff);
    assign wrap      = (col_inc >= w_eff);
    assign sum_new   = sum_reg + ((!extend || col_end) ? sq_full[SUM_W-1:0] : '0);
    assign max_base  = (first_row && col_reg == '0) ? '0 : max_reg;
    assign max_new   = (sum_new > max_base) ? sum_new : max_base;

    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        run_next  = run_reg;
        prev_next = prev_reg;
        sum_next  = sum_reg;
        max_next  = max_reg;
        if (pix_en)
        begin
            if (col_end)
            begin
                row_next  = '0;
                col_next  = wrap ? '0 : col_inc[COL_W-1:0];
                run_next  = '0;
                prev_next = 1'b0;
                sum_next  = '0;
                max_next  = max_new;
            end
            else
            begin
                row_next  = row_inc[ROW_W-1:0];
                run_next  = extend ? run_inc : '0;
                prev_next = pixel;
                sum_next  = sum_new;
                max_next  = max_base;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            run_reg  <= '0;
            prev_reg <= 1'b0;
            sum_reg  <= '0;
            max_reg  <= '0;
        end
        else
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            run_reg  <= run_next;
            prev_reg <= prev_next;
            sum_reg  <= sum_next;
            max_reg  <= max_next;
        end
    end

    assign wr.en   = pix_en && col_end;
    assign wr.addr = col_reg;
    assign wr.data = sum_new;
    assign max_sum = max_reg;

endmodule

[src/crep_div.sv]
module crep_div
    import crep_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [SUM_W-1:0] divisor,
    input  logic             take,
    output logic             done,
    output div_res_t         res
);

    localparam int CNT_W = $clog2(FRAC_W) + 1;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [SUM_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  div_reg, div_next;
    logic [FRAC_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              sat_reg, sat_next;
    logic              zero_reg, zero_next;

    logic [SUM_W:0] rem2;
    logic [SUM_W:0] diff;
    logic           ge;

    assign rem2 = {rem_reg, 1'b0};
    assign diff = rem2 - {1'b0, div_reg};
    assign ge   = (rem2 >= {1'b0, div_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        sat_next  = sat_reg;
        zero_next = zero_reg;
        if (busy_reg)
        begin
            rem_next = ge ? diff[SUM_W-1:0] : rem2[SUM_W-1:0];
            quo_next = {quo_reg[FRAC_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (done_reg)
        begin
            if (take)
            begin
                done_next = 1'b0;
            end
        end
        else if (start)
        begin
            quo_next  = '0;
            div_next  = divisor;
            rem_next  = dividend;
            cnt_next  = CNT_W'(FRAC_W);
            zero_next = (divisor == '0);
            sat_next  = (divisor != '0) && (dividend >= divisor);
            if (divisor == '0 || dividend >= divisor)
            begin
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
        sat_reg  <= sat_next;
        zero_reg <= zero_next;
    end

    assign done         = done_reg;
    assign res.value    = sat_reg ? Q_ONE : {1'b0, quo_reg};
    assign res.max_zero = zero_reg;

endmodule

[src/column_white_run_energy_profile.sv]
// Pixel items: one per cycle, no result; a finished column is written to the
//   column store in the same cycle as its last pixel.
// Read items: the stored column sum is registered, then the 16-step radix-2
//   divider runs unless the quotient saturates or the maximum is zero.
// A read blocks further items until its result enters the output register.
// Reset clears control state and sets both dimensions to 1024; the column store
//   is not cleared and holds no defined value until a column is written.
`include "column_white_run_energy_profile_assert.svh"

module column_white_run_energy_profile
    import crep_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    crep_req_if.sink             req,
    crep_rsp_if.source           rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [DIM_W-1:0]    width_reg, height_reg;
    logic [COLUMN_W-1:0] col_reg;
    logic                oor_reg;
    logic                out_valid_reg, out_valid_next;
    logic [Q_W-1:0]      value_reg;
    logic                zero_reg;
    logic [COLUMN_W-1:0] echo_reg;

    logic             accept;
    logic             pix_en;
    logic             rd_en;
    logic             out_free;
    logic             load_out;
    colmem_wr_t       wr;
    logic [SUM_W-1:0] rd_data;
    logic [SUM_W-1:0] max_sum;
    logic             div_done;
    div_res_t         div_res;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign pix_en    = accept && (req.cmd == CMD_PIXEL);
    assign rd_en     = accept && (req.cmd == CMD_READ);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign load_out  = (state_reg == ST_DIV) && div_done && out_free;

    crep_accum u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix_en       (pix_en),
        .pixel        (req.pixel),
        .image_width  (width_reg),
        .image_height (height_reg),
        .wr           (wr),
        .max_sum      (max_sum)
    );

    crep_colmem u_colmem (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (req.column[COL_W-1:0]),
        .rd_data (rd_data)
    );

    crep_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_READ),
        .dividend (oor_reg ? '0 : rd_data),
        .divisor  (max_sum),
        .take     (load_out),
        .done     (div_done),
        .res      (div_res)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (rd_en)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            width_reg     <= DIM_RESET;
            height_reg    <= DIM_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            col_reg <= req.column;
            oor_reg <= (32'(req.column) >= MAX_WIDTH);
        end
        if (load_out)
        begin
            value_reg <= div_res.value;
            zero_reg  <= div_res.max_zero;
            echo_reg  <= col_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.value_q16    = value_reg;
    assign rsp.max_was_zero = zero_reg;
    assign rsp.column_echo  = echo_reg;

    `CREP_ASSERT_IMP(a_value_bound, rsp.valid, rsp.value_q16 <= Q_ONE)
    `CREP_ASSERT_IMP(a_zero_value, rsp.valid && rsp.max_was_zero, rsp.value_q16 == '0)
    `CREP_ASSERT_NXT(a_read_blocks, req.valid && req.ready && req.cmd == CMD_READ, !req.ready)

endmodule
